>>> sv/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg
// Shared constants, types and lookup tables for the keypad scanner.
// ----------------------------------------------------------------------------
package kse_pkg;

	localparam int BufferDigits  = 4;   // depth of the digit entry buffer, 1 to 16
	localparam int DisplayDigits = 4;   // buffer positions shown on the result bus
	localparam int Rows          = 4;
	localparam int Cols          = 4;
	localparam int DigitW        = 4;
	localparam int KeyW          = 8;
	localparam int SegW          = 7;
	localparam int InW           = Rows * Cols;
	localparam int OutW          = KeyW + SegW + 1 + DisplayDigits * DigitW;

	localparam logic [KeyW-1:0] NoKey = 8'hFF;

	typedef logic [DigitW-1:0] digit_t;

	typedef struct packed {
		logic [KeyW-1:0] key_code;
		logic [SegW-1:0] segment;
		logic            pressed;
		logic            enterable;   // codes 1 to 15
	} decode_t;

	// Key layout, index {row, column}, both counted from zero:
	//   1 2 3 A / 4 5 6 B / 7 8 9 C / E 0 F D
	localparam digit_t KeyMap [Rows*Cols] = '{
		4'h1, 4'h2, 4'h3, 4'hA,
		4'h4, 4'h5, 4'h6, 4'hB,
		4'h7, 4'h8, 4'h9, 4'hC,
		4'hE, 4'h0, 4'hF, 4'hD
	};

	// Segment bits gfedcba for hex digits 0 to F.
	localparam logic [SegW-1:0] SegMap [16] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
	};

endpackage

>>> sv/kse_decode.sv
// ----------------------------------------------------------------------------
// kse_decode
// Priority decode of one matrix snapshot into a key code and segment pattern.
// ----------------------------------------------------------------------------
module kse_decode (
	input  logic [kse_pkg::InW-1:0] columns,   // row1 [3:0] .. row4 [15:12]
	output kse_pkg::decode_t        dec
);

	logic [1:0] row_sel;
	logic [1:0] col_sel;
	logic       hit;
	logic [3:0] row_bits;
	kse_pkg::digit_t code;

	// First active row wins.
	always_comb begin
		row_sel  = 2'd0;
		hit      = 1'b1;
		row_bits = columns[3:0];
		priority if (columns[3:0] != 4'd0) begin
			row_sel  = 2'd0;
			row_bits = columns[3:0];
		end else if (columns[7:4] != 4'd0) begin
			row_sel  = 2'd1;
			row_bits = columns[7:4];
		end else if (columns[11:8] != 4'd0) begin
			row_sel  = 2'd2;
			row_bits = columns[11:8];
		end else if (columns[15:12] != 4'd0) begin
			row_sel  = 2'd3;
			row_bits = columns[15:12];
		end else begin
			hit = 1'b0;
		end
	end

	// Highest column within that row wins.
	always_comb begin
		priority if (row_bits[3]) begin
			col_sel = 2'd3;
		end else if (row_bits[2]) begin
			col_sel = 2'd2;
		end else if (row_bits[1]) begin
			col_sel = 2'd1;
		end else begin
			col_sel = 2'd0;
		end
	end

	assign code = kse_pkg::KeyMap[{row_sel, col_sel}];

	always_comb begin
		dec.pressed   = hit;
		dec.enterable = hit && (code != 4'd0);
		if (hit) begin
			dec.key_code = {{(kse_pkg::KeyW - kse_pkg::DigitW){1'b0}}, code};
			dec.segment  = kse_pkg::SegMap[code];
		end else begin
			dec.key_code = kse_pkg::NoKey;
			dec.segment  = '0;
		end
	end

endmodule

>>> sv/keypad_scan_digit_entry.sv
// ----------------------------------------------------------------------------
// keypad_scan_digit_entry: matrix keypad decode with digit entry buffer
// Takes one request per cycle while the output is not stalled.
// Input register, single-pass decode/update, result register; stalls hold both.
// Async reset clears valids, press latch and digit buffer to zero.
// ----------------------------------------------------------------------------
module keypad_scan_digit_entry (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// row1_columns [3:0], row2_columns [7:4], row3_columns [11:8], row4_columns [15:12]
	input  logic [kse_pkg::InW-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// key_code [7:0], segment_pattern [14:8], entered [15], digit_oldest [19:16],
	// digit_second [23:20], digit_third [27:24], digit_newest [31:28]
	output logic [kse_pkg::OutW-1:0] m_axis_tdata
);

	// Input stage: holds one snapshot request.
	logic                    valid_s1;
	logic [kse_pkg::InW-1:0] columns_s1;

	// Result stage.
	logic                     valid_s2;
	logic [kse_pkg::OutW-1:0] result_s2;

	// Block state.
	logic            press_latch_q;
	kse_pkg::digit_t digits_q [kse_pkg::BufferDigits];

	kse_pkg::decode_t dec;
	logic             advance;
	logic             enter;
	kse_pkg::digit_t  digits_next [kse_pkg::BufferDigits];
	logic [kse_pkg::DisplayDigits*kse_pkg::DigitW-1:0] shown;

	// Advance the input stage when the result register is free or drains now.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	kse_decode u_decode (
		.columns (columns_s1),
		.dec     (dec)
	);

	// Admit one digit per press; key 0 neither sets nor releases the latch.
	assign enter = dec.enterable && !press_latch_q;

	// Shift toward the oldest end and drop the new digit in the newest slot.
	always_comb begin
		for (int i = 0; i < kse_pkg::BufferDigits - 1; i++) begin
			digits_next[i] = enter ? digits_q[i+1] : digits_q[i];
		end
		digits_next[kse_pkg::BufferDigits-1] = enter ? dec.key_code[kse_pkg::DigitW-1:0]
			: digits_q[kse_pkg::BufferDigits-1];
	end

	// Display positions past the buffer depth read zero.
	for (genvar p = 0; p < kse_pkg::DisplayDigits; p++) begin : g_show
		if (p < kse_pkg::BufferDigits) begin : g_live
			assign shown[p*kse_pkg::DigitW +: kse_pkg::DigitW] = digits_next[p];
		end else begin : g_zero
			assign shown[p*kse_pkg::DigitW +: kse_pkg::DigitW] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			columns_s1 <= s_axis_tdata;
		end
	end

	// State moves only when a request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_latch_q <= 1'b0;
			for (int i = 0; i < kse_pkg::BufferDigits; i++) begin
				digits_q[i] <= '0;
			end
		end else if (advance) begin
			if (enter) begin
				press_latch_q <= 1'b1;
			end else if (!dec.pressed) begin
				press_latch_q <= 1'b0;
			end
			digits_q <= digits_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= {shown, enter, dec.segment, dec.key_code};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

endmodule
